[rtl/dctp_pkg.sv]
package dctp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned DIR_W   = 2;
    localparam int unsigned MAG_W   = 7;
    localparam int unsigned NUM_CMD = 6;
    // The sixth command byte is used in the cycle it arrives and is never stored.
    localparam int unsigned NUM_CAP = NUM_CMD - 1;
    localparam int unsigned SLOT_W  = 3;
    // Two ASCII digits give hi*10 + lo; the offset removes the '0' bias of both.
    localparam int unsigned SUM_W   = 12;

    localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
    localparam logic [BYTE_W-1:0] CH_I   = 8'h49;
    localparam logic [BYTE_W-1:0] CH_D   = 8'h44;
    localparam logic [BYTE_W-1:0] CH_N   = 8'h4E;
    localparam logic [BYTE_W-1:0] CH_S   = 8'h53;
    localparam logic [BYTE_W-1:0] CH_W   = 8'h57;
    localparam logic [BYTE_W-1:0] CH_E   = 8'h45;

    localparam logic [SUM_W-1:0] MAG_OFFSET = 12'd528;
    localparam logic [SUM_W-1:0] MAG_TOP    = 12'd628;
    localparam logic [MAG_W:0]   BAD_SUM_A  = 8'd1;
    localparam logic [MAG_W:0]   BAD_SUM_B  = 8'd5;

    localparam logic [DIR_W-1:0] HEADING_NORTH = 2'd0;
    localparam logic [DIR_W-1:0] HEADING_SOUTH = 2'd1;
    localparam logic [DIR_W-1:0] HEADING_WEST  = 2'd2;
    localparam logic [DIR_W-1:0] HEADING_EAST  = 2'd3;

    typedef enum logic [3:0] {
        PH_SEARCH,
        PH_SEEN_I,
        PH_SKIP0,
        PH_SKIP1,
        PH_CAP0,
        PH_CAP1,
        PH_CAP2,
        PH_CAP3,
        PH_CAP4,
        PH_CAP5,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic             valid;
        logic [DIR_W-1:0] code;
    } dir_t;

    typedef struct packed {
        logic             valid;
        logic [MAG_W-1:0] value;
    } mag_t;

    function automatic dir_t dir_decode(input logic [BYTE_W-1:0] c);
        dir_t d;
        d.valid = 1'b1;
        d.code  = HEADING_NORTH;
        unique case (c)
            CH_N:    d.code = HEADING_NORTH;
            CH_S:    d.code = HEADING_SOUTH;
            CH_W:    d.code = HEADING_WEST;
            CH_E:    d.code = HEADING_EAST;
            default: d.valid = 1'b0;
        endcase
        return d;
    endfunction

    function automatic mag_t mag_decode(input logic [BYTE_W-1:0] hi,
                                        input logic [BYTE_W-1:0] lo);
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] diff;
        mag_t m;
        sum     = SUM_W'({hi, 3'b000}) + SUM_W'({hi, 1'b0}) + SUM_W'(lo);
        diff    = sum - MAG_OFFSET;
        m.valid = (sum >= MAG_OFFSET) && (sum <= MAG_TOP);
        m.value = diff[MAG_W-1:0];
        return m;
    endfunction

endpackage

[rtl/drive_command_text_parser.sv]
// Channel | Beat content                                   | Handshake
// s_      | tdata[7:0] in_byte, tlast end_of_message       | s_tvalid / s_tready
// m_      | tuser ok, tdata first/second direction+mag     | m_tvalid / m_tready
//
// One input beat per cycle while s_tready is high; the whole per-byte decision is one pass of logic
// from the incoming beat and the phase register into the output register.
// A result appears on m_ in the cycle after the beat that completes or ends the command.
// Synchronous active-low reset returns the parser to the search for "ID".
// s_tready drops only while a result is held and m_tready is low.
module drive_command_text_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [1:0] first_direction, [8:2] first_magnitude,
                                   // [10:9] second_direction, [17:11] second_magnitude,
                                   // [23:18] zero
    output logic        m_tuser    // ok
);
    import dctp_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   cap_reg [NUM_CAP];
    logic                out_valid_reg, out_valid_next;
    logic                out_ok_reg, out_ok_next;
    logic [17:0]         out_data_reg, out_data_next;

    logic                s_fire;
    logic                cap_active;
    logic [SLOT_W-1:0]   slot;
    logic                cap_we;
    logic                emit;
    logic [BYTE_W-1:0]   cmd [NUM_CMD];
    dir_t                dir1, dir2;
    mag_t                mag1, mag2;
    logic [MAG_W:0]      mag_total;
    logic                cmd_ok;

    assign s_fire     = s_tvalid && s_tready;
    assign s_tready   = !out_valid_reg || m_tready;
    assign cap_active = (phase_reg >= PH_CAP0) && (phase_reg <= PH_CAP5);
    assign slot       = SLOT_W'(phase_reg - PH_CAP0);

    // Command bytes as seen after this beat: stored bytes, the current byte in
    // its slot, and zero for anything the string never delivered.
    always_comb begin
        for (int i = 0; i < NUM_CAP; i++) begin
            if (cap_active && (SLOT_W'(i) < slot)) begin
                cmd[i] = cap_reg[i];
            end else if (cap_active && (SLOT_W'(i) == slot)) begin
                cmd[i] = s_tdata;
            end else begin
                cmd[i] = CH_NUL;
            end
        end
        cmd[NUM_CMD-1] = (cap_active && (slot == SLOT_W'(NUM_CAP))) ? s_tdata : CH_NUL;
    end

    assign dir1      = dir_decode(cmd[0]);
    assign mag1      = mag_decode(cmd[1], cmd[2]);
    assign dir2      = dir_decode(cmd[3]);
    assign mag2      = mag_decode(cmd[4], cmd[5]);
    assign mag_total = {1'b0, mag1.value} + {1'b0, mag2.value};
    assign cmd_ok    = dir1.valid && mag1.valid && dir2.valid && mag2.valid
                       && (mag_total != BAD_SUM_A) && (mag_total != BAD_SUM_B);

    always_comb begin
        phase_next = phase_reg;
        cap_we     = 1'b0;
        emit       = 1'b0;
        if (phase_reg != PH_DONE) begin
            if (s_tdata == CH_NUL) begin
                emit = 1'b1;
            end else begin
                unique case (phase_reg)
                    PH_SEARCH: begin
                        if (s_tdata == CH_I) phase_next = PH_SEEN_I;
                    end
                    PH_SEEN_I: begin
                        if (s_tdata == CH_D) begin
                            phase_next = PH_SKIP0;
                        end else if (s_tdata != CH_I) begin
                            phase_next = PH_SEARCH;
                        end
                    end
                    PH_SKIP0: phase_next = PH_SKIP1;
                    PH_SKIP1: phase_next = PH_CAP0;
                    PH_CAP0: begin
                        cap_we     = 1'b1;
                        phase_next = PH_CAP1;
                    end
                    PH_CAP1: begin
                        cap_we     = 1'b1;
                        phase_next = PH_CAP2;
                    end
                    PH_CAP2: begin
                        cap_we     = 1'b1;
                        phase_next = PH_CAP3;
                    end
                    PH_CAP3: begin
                        cap_we     = 1'b1;
                        phase_next = PH_CAP4;
                    end
                    PH_CAP4: begin
                        cap_we     = 1'b1;
                        phase_next = PH_CAP5;
                    end
                    PH_CAP5: emit = 1'b1;
                    default: phase_next = PH_SEARCH;
                endcase
            end
            if (s_tlast) emit = 1'b1;
        end
        if (emit) phase_next = PH_DONE;
        if (s_tlast) phase_next = PH_SEARCH;
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_ok_next    = out_ok_reg;
        out_data_next  = out_data_reg;
        if (s_fire && emit) begin
            out_valid_next = 1'b1;
            out_ok_next    = cmd_ok;
            out_data_next  = cmd_ok ? {mag2.value, dir2.code, mag1.value, dir1.code} : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SEARCH;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (s_fire) phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_ok_reg   <= out_ok_next;
        out_data_reg <= out_data_next;
        if (s_fire && cap_we) cap_reg[slot] <= s_tdata;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = {6'd0, out_data_reg};

`ifndef SYNTH
    // A rejected command carries no direction or magnitude.
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 24'd0))
        else $error("rejected result carries nonzero payload");

    // An accepted command never reports a magnitude above one hundred.
    a_mag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> ((m_tdata[8:2] <= 7'd100) && (m_tdata[17:11] <= 7'd100)))
        else $error("magnitude out of range");

    // After a result inside a message, the rest of that message is ignored.
    a_done_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && emit && !s_tlast) |=> (phase_reg == PH_DONE))
        else $error("parser did not close the message after its result");

    // The last beat of a message always restarts the search.
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> (phase_reg == PH_SEARCH))
        else $error("parser did not restart after end of message");

    // Every message end yields a result unless one was already given.
    a_result_per_message: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast && (phase_reg != PH_DONE)) |=> m_tvalid)
        else $error("message ended without a result");
`endif

endmodule

[bench/tb_top.sv]
module tb_top;
    import dctp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_BEATS  = 460;
    localparam int N_DIR       = 16;

    typedef struct packed {
        logic             ok;
        logic [DIR_W-1:0] first_dir;
        logic [MAG_W-1:0] first_mag;
        logic [DIR_W-1:0] second_dir;
        logic [MAG_W-1:0] second_mag;
    } cmd_result_t;

    localparam cmd_result_t REJECTED = '0;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;

    drive_command_text_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Directed messages. '#' stands for a zero byte and '~' for 8'hFF; the last
    // character of each message is sent with tlast.
    string dir_msg [N_DIR] = '{
        "IDabN05E10", "IDabS00W00", "IDabN:0S:0", "IDabN:1S00",
        "IDabN01S00", "IDabN02S03", "IDabX01S10", "IDabN/9S10",
        "xyzI",       "IIDabW10E20", "~ID~~E99W01xyz", "IDabN1#IDabN05E10",
        "ID",         "#",          "IDxyW03N01", "IDabE5"
    };
    bit dir_typed [N_DIR] = '{
        1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 1, 1, 1, 0, 1
    };
    cmd_result_t dir_want [N_DIR] = '{
        '{1'b1, HEADING_NORTH, 7'd5, HEADING_EAST, 7'd10},
        '{1'b1, HEADING_SOUTH, 7'd0, HEADING_WEST, 7'd0},
        '{1'b1, HEADING_NORTH, 7'd100, HEADING_SOUTH, 7'd100},
        REJECTED, REJECTED, REJECTED, REJECTED, REJECTED, REJECTED,
        REJECTED, REJECTED, REJECTED, REJECTED, REJECTED, REJECTED, REJECTED
    };

    // Parser state as seen by the predictor.
    phase_t      parse_phase;
    logic [7:0]  cmd_bytes [6];
    bit          result_given;

    cmd_result_t expected_results [$];
    logic [7:0]  msg_bytes [$];
    cmd_result_t seen_want;

    bit quiet;
    int mismatch_count;
    int beats_sent;
    int messages_sent;
    int results_seen;
    int ok_seen;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d (beat %0d)", what, got, want, beats_sent);
        mismatch_count++;
    endtask

    function automatic int heading_code(input logic [7:0] c);
        case (c)
            CH_N:    return HEADING_NORTH;
            CH_S:    return HEADING_SOUTH;
            CH_W:    return HEADING_WEST;
            CH_E:    return HEADING_EAST;
            default: return -1;
        endcase
    endfunction

    function automatic int digit_pair_value(input logic [7:0] hi, input logic [7:0] lo);
        return (int'(hi) - 48) * 10 + (int'(lo) - 48);
    endfunction

    function automatic cmd_result_t judge_command();
        cmd_result_t r;
        int h1, h2, v1, v2;
        r = REJECTED;
        if (parse_phase < PH_SKIP0)
            return r;
        h1 = heading_code(cmd_bytes[0]);
        v1 = digit_pair_value(cmd_bytes[1], cmd_bytes[2]);
        h2 = heading_code(cmd_bytes[3]);
        v2 = digit_pair_value(cmd_bytes[4], cmd_bytes[5]);
        if (h1 < 0 || h2 < 0 || v1 < 0 || v1 > 100 || v2 < 0 || v2 > 100)
            return r;
        if (v1 + v2 == int'(BAD_SUM_A) || v1 + v2 == int'(BAD_SUM_B))
            return r;
        r.ok         = 1'b1;
        r.first_dir  = h1[DIR_W-1:0];
        r.first_mag  = v1[MAG_W-1:0];
        r.second_dir = h2[DIR_W-1:0];
        r.second_mag = v2[MAG_W-1:0];
        return r;
    endfunction

    // The string ended early: command bytes not yet captured read as zero.
    task automatic close_string(output cmd_result_t r);
        int from;
        from = 0;
        if (parse_phase >= PH_CAP0 && parse_phase < PH_DONE)
            from = int'(parse_phase) - int'(PH_CAP0);
        for (int i = from; i < 6; i++)
            cmd_bytes[i] = 8'h00;
        r = judge_command();
        result_given = 1'b1;
    endtask

    task automatic predict_beat(input logic [7:0] b, input bit last,
                                output bit produced, output cmd_result_t r);
        produced = 1'b0;
        r = REJECTED;
        if (!result_given) begin
            if (b == CH_NUL) begin
                close_string(r);
                produced = 1'b1;
            end else begin
                case (parse_phase)
                    PH_SEARCH: begin
                        if (b == CH_I)
                            parse_phase = PH_SEEN_I;
                    end
                    PH_SEEN_I: begin
                        if (b == CH_D)
                            parse_phase = PH_SKIP0;
                        else if (b != CH_I)
                            parse_phase = PH_SEARCH;
                    end
                    PH_SKIP0: parse_phase = PH_SKIP1;
                    PH_SKIP1: parse_phase = PH_CAP0;
                    PH_DONE: ;
                    default: begin
                        cmd_bytes[int'(parse_phase) - int'(PH_CAP0)] = b;
                        parse_phase = phase_t'(parse_phase + 1);
                        if (parse_phase == PH_DONE) begin
                            r = judge_command();
                            result_given = 1'b1;
                            produced = 1'b1;
                        end
                    end
                endcase
            end
            if (last && !result_given) begin
                close_string(r);
                produced = 1'b1;
            end
        end
        if (last) begin
            parse_phase  = PH_SEARCH;
            result_given = 1'b0;
        end
    endtask

    // Sends msg_bytes as one message; typed rows replace the predicted result.
    task automatic send_message(input bit typed, input cmd_result_t want);
        bit          produced;
        cmd_result_t r;
        int          gap;
        for (int i = 0; i < msg_bytes.size(); i++) begin
            @(negedge aclk);
            s_tvalid <= 1'b1;
            s_tdata  <= msg_bytes[i];
            s_tlast  <= (i == msg_bytes.size() - 1);
            @(posedge aclk);
            while (!s_tready)
                @(posedge aclk);
            predict_beat(msg_bytes[i], i == msg_bytes.size() - 1, produced, r);
            if (produced)
                expected_results.push_back(typed ? want : r);
            beats_sent++;
            if (!quiet && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 11);
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1)
                    @(negedge aclk);
            end
        end
        messages_sent++;
    endtask

    function automatic logic [7:0] text_byte();
        if ($urandom_range(0, 3) == 0)
            return CH_I;
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] heading_byte();
        case ($urandom_range(0, 9))
            0:       return CH_N;
            1, 2:    return CH_S;
            3, 4:    return CH_W;
            5, 6, 7: return CH_E;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic push_mag(input int v);
        logic [7:0] hi, lo;
        hi = 8'(48 + v / 10);
        lo = 8'(48 + v % 10);
        // Now and then a digit is replaced by a byte from 40 to 70, often outside '0'..'9'.
        if ($urandom_range(0, 9) == 0)
            hi = 8'($urandom_range(40, 70));
        else if ($urandom_range(0, 9) == 0)
            lo = 8'($urandom_range(40, 70));
        msg_bytes.push_back(hi);
        msg_bytes.push_back(lo);
    endtask

    task automatic build_message();
        int n, s, v1, v2, cut;
        msg_bytes.delete();
        if ($urandom_range(0, 9) >= 7) begin
            n = $urandom_range(1, 16);
            repeat (n)
                msg_bytes.push_back(($urandom_range(0, 9) == 0) ? CH_NUL
                                                               : 8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 3))
                msg_bytes.push_back(text_byte());
            if ($urandom_range(0, 3) == 0)
                msg_bytes.push_back(CH_I);
            msg_bytes.push_back(CH_I);
            msg_bytes.push_back(CH_D);
            repeat (2)
                msg_bytes.push_back(8'($urandom_range(1, 255)));
            case ($urandom_range(0, 5))
                0:       s = int'(BAD_SUM_A);
                1:       s = int'(BAD_SUM_B);
                default: s = -1;
            endcase
            if (s >= 0) begin
                v1 = $urandom_range(0, s);
                v2 = s - v1;
            end else begin
                v1 = $urandom_range(0, 100);
                v2 = $urandom_range(0, 100);
            end
            msg_bytes.push_back(heading_byte());
            push_mag(v1);
            msg_bytes.push_back(heading_byte());
            push_mag(v2);
            repeat ($urandom_range(0, 3))
                msg_bytes.push_back(text_byte());
            case ($urandom_range(0, 7))
                0: msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = CH_NUL;
                1: begin
                    cut = $urandom_range(1, msg_bytes.size());
                    while (msg_bytes.size() > cut)
                        void'(msg_bytes.pop_back());
                end
                default: ;
            endcase
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT)
            @(posedge aclk);
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11))
                    @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser)
                ok_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result beat, ok", m_tuser, 0);
            end else begin
                seen_want = expected_results.pop_front();
                if (m_tuser !== seen_want.ok)
                    report_mismatch("ok", m_tuser, seen_want.ok);
                if (m_tdata[1:0] !== seen_want.first_dir)
                    report_mismatch("first_direction", m_tdata[1:0], seen_want.first_dir);
                if (m_tdata[8:2] !== seen_want.first_mag)
                    report_mismatch("first_magnitude", m_tdata[8:2], seen_want.first_mag);
                if (m_tdata[10:9] !== seen_want.second_dir)
                    report_mismatch("second_direction", m_tdata[10:9], seen_want.second_dir);
                if (m_tdata[17:11] !== seen_want.second_mag)
                    report_mismatch("second_magnitude", m_tdata[17:11],
                                    seen_want.second_mag);
                if (m_tdata[23:18] !== 6'd0)
                    report_mismatch("tdata padding", m_tdata[23:18], 0);
            end
        end
    end

    initial begin
        int  rand_start;
        bit  paused_once;
        byte c;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        quiet    = 1'b0;
        paused_once  = 1'b0;
        parse_phase  = PH_SEARCH;
        result_given = 1'b0;
        for (int i = 0; i < 6; i++)
            cmd_bytes[i] = 8'h00;
        repeat (3)
            @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int row = 0; row < N_DIR; row++) begin
            msg_bytes.delete();
            for (int k = 0; k < dir_msg[row].len(); k++) begin
                c = dir_msg[row][k];
                if (c == "#")
                    msg_bytes.push_back(CH_NUL);
                else if (c == "~")
                    msg_bytes.push_back(8'hFF);
                else
                    msg_bytes.push_back(8'(c));
            end
            send_message(dir_typed[row], dir_want[row]);
        end

        // Let the directed results drain before the random part starts.
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);

        rand_start = beats_sent;
        while (beats_sent - rand_start < RAND_BEATS) begin
            if (!paused_once && beats_sent - rand_start >= RAND_BEATS / 2) begin
                paused_once = 1'b1;
                @(negedge aclk);
                s_tvalid <= 1'b0;
                while (expected_results.size() != 0)
                    @(posedge aclk);
            end
            quiet = (beats_sent - rand_start >= RAND_BEATS - 80);
            build_message();
            send_message(1'b0, REJECTED);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (8)
            @(posedge aclk);

        $display("Sent %0d beats in %0d messages; %0d results checked, %0d accepted commands.",
                 beats_sent, messages_sent, results_seen, ok_seen);
        $display("Covered directed edge cases, well-formed and broken random messages, stalls.");
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
rtl/dctp_pkg.sv
rtl/drive_command_text_parser.sv
bench/tb_top.sv
